// ===== sv/pidcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register indexes and status types for the PID step core.
package pidcs_pkg;

  // Number format of every value: Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Field widths.
  localparam int VAL_W = 32;
  localparam int DT_W  = 31;

  // The integral is held as Q32.16 and saturates at its own width.
  localparam int SUM_W = (DATA_WIDTH + FRAC_BITS > 62) ? 62 : DATA_WIDTH + FRAC_BITS;

  // Error difference, derivative dividend and signed rate.
  localparam int DIFF_W = VAL_W + 1;
  localparam int NUM_W  = DIFF_W + FRAC_BITS;
  localparam int RATE_W = NUM_W + 1;

  // Shared multiplier operands, accumulator and saturated product.
  localparam int MUL_A_W   = VAL_W;
  localparam int MUL_B_W   = (RATE_W > SUM_W) ? RATE_W : SUM_W;
  localparam int ACC_W     = MUL_A_W + MUL_B_W - 1;
  localparam int TERM_W    = 62;
  localparam int MUL_CHUNK = 16;

  // Total of the three terms.
  localparam int TOTAL_W = TERM_W + 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET        = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ===== sv/pidcs_mul.sv =====
`timescale 1ns / 1ps
// Iterative signed fractional multiplier with saturation of the product.
module pidcs_mul #(
  parameter int CHUNK = pidcs_pkg::MUL_CHUNK
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [pidcs_pkg::MUL_A_W-1:0]   a,
  input  logic signed [pidcs_pkg::MUL_B_W-1:0]   b,
  output pidcs_pkg::mul_stat_t                   stat,
  output logic signed [pidcs_pkg::TERM_W-1:0]    result
);
  import pidcs_pkg::*;

  localparam int NCHUNK = (MUL_B_W + CHUNK - 1) / CHUNK;
  localparam int B_PAD  = NCHUNK * CHUNK;
  localparam int CNT_W  = $clog2(NCHUNK + 1);
  localparam int HI_W   = ACC_W + 2 - TERM_W;

  logic [MUL_A_W-1:0]         a_mag;
  logic [B_PAD-1:0]           b_mag;
  logic                       neg;
  logic [ACC_W-1:0]           acc;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic                       fin;
  logic                       done;
  logic [MUL_A_W-1:0]         a_abs;
  logic [MUL_B_W-1:0]         b_abs;
  logic [MUL_A_W+CHUNK-1:0]   part;
  logic signed [ACC_W:0]      sprod;
  logic signed [ACC_W:0]      shifted;
  logic [HI_W-1:0]            hi;

  always_comb begin
    a_abs   = a[MUL_A_W-1] ? (~a + 1'b1) : a;
    b_abs   = b[MUL_B_W-1] ? (~b + 1'b1) : b;
    part    = a_mag * b_mag[B_PAD-1 -: CHUNK];
    sprod   = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
    shifted = sprod >>> FRAC_BITS;
    hi      = shifted[ACC_W:TERM_W-1];
  end

  // The multiplier operand is consumed one chunk a cycle, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_mag <= a_abs;
        b_mag <= B_PAD'(b_abs);
        neg   <= a[MUL_A_W-1] ^ b[MUL_B_W-1];
        acc   <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        acc   <= (acc << CHUNK) + ACC_W'(part);
        b_mag <= b_mag << CHUNK;
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(NCHUNK - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        if ((hi == '0) || (hi == '1)) begin
          result <= shifted[TERM_W-1:0];
        end else if (shifted[ACC_W]) begin
          result <= {1'b1, {(TERM_W-1){1'b0}}};
        end else begin
          result <= {1'b0, {(TERM_W-1){1'b1}}};
        end
      end
    end
  end

  assign stat.busy = busy | fin;
  assign stat.done = done;

endmodule

// ===== sv/pidcs_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the derivative rate.
module pidcs_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pidcs_pkg::NUM_W-1:0]     num,
  input  logic [pidcs_pkg::DT_W-1:0]      den,
  output logic                            busy,
  output logic [pidcs_pkg::NUM_W-1:0]     quot
);
  import pidcs_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DT_W-1:0]  rem;
  logic [NUM_W-1:0] quo;
  logic [DT_W-1:0]  den_r;
  logic [CNT_W-1:0] cnt;
  logic [DT_W:0]    trial;
  logic [DT_W+1:0]  sub;
  logic             take;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    sub   = {1'b0, trial} - {2'b00, den_r};
    take  = ~sub[DT_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        rem   <= '0;
        quo   <= num;
        den_r <= den;
        cnt   <= CNT_W'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= take ? sub[DT_W-1:0] : trial[DT_W-1:0];
        quo <= {quo[NUM_W-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quot = quo;

endmodule

// ===== sv/pid_controller_step_core.sv =====
`timescale 1ns / 1ps
// Top level of the PID step core: registers, sequencer and output stage.
//
//   channel   signals                               direction  transfer when
//   -------   ------------------------------------  ---------  -----------------------------
//   sample    sample_valid/ready, measured, step_time  in       sample_valid & sample_ready
//   drive     drive_valid/ready, drive              out        drive_valid & drive_ready
//   config    cfg_write, cfg_index, cfg_data        in         cfg_write
//
// A sample's drive value is presented as the sequencer returns to idle, so the core is
// ready for the next sample in that same cycle; it takes no new sample before then.
// The divider produces one quotient bit per cycle for the 49-bit derivative dividend and
// is followed by one four-chunk pass of the shared multiplier for the derivative term;
// the other three multiplies run while the divider works.
// Reset is synchronous and clears the integral, the last error, the gains (to zero) and the
// setpoint, and opens the output limits to the full range. A result that is not taken waits
// in the output register; the next sample is accepted meanwhile, and the sequencer holds
// before its final step until the output register is free.
module pid_controller_step_core #(
  parameter int MUL_CHUNK = pidcs_pkg::MUL_CHUNK
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [pidcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pidcs_pkg::VAL_W-1:0]           cfg_data,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  logic signed [pidcs_pkg::VAL_W-1:0]    measured,
  input  logic [pidcs_pkg::DT_W-1:0]            step_time,
  output logic                                  drive_valid,
  input  logic                                  drive_ready,
  output logic signed [pidcs_pkg::VAL_W-1:0]    drive
);
  import pidcs_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PREP     = 4'd1;
  localparam logic [3:0] S_MUL_INT  = 4'd2;
  localparam logic [3:0] S_START_P  = 4'd3;
  localparam logic [3:0] S_MUL_P    = 4'd4;
  localparam logic [3:0] S_MUL_I    = 4'd5;
  localparam logic [3:0] S_WAIT_DIV = 4'd6;
  localparam logic [3:0] S_START_D  = 4'd7;
  localparam logic [3:0] S_MUL_D    = 4'd8;
  localparam logic [3:0] S_CLAMP    = 4'd9;

  localparam int SHI_W = TERM_W + 2 - SUM_W;

  // Configuration registers.
  logic signed [VAL_W-1:0] gain_p;
  logic signed [VAL_W-1:0] gain_i;
  logic signed [VAL_W-1:0] gain_d;
  logic signed [VAL_W-1:0] drive_floor;
  logic signed [VAL_W-1:0] drive_ceiling;
  logic signed [VAL_W-1:0] target;

  // Controller state and working registers.
  logic [3:0]                state;
  logic signed [SUM_W-1:0]   error_sum;
  logic signed [VAL_W-1:0]   prior_error;
  logic signed [VAL_W-1:0]   err;
  logic [DT_W-1:0]           dt;
  logic                      dneg;
  logic signed [RATE_W-1:0]  rate;
  logic signed [TOTAL_W-1:0] term_sum;

  // Shared unit hookup.
  logic                       mul_start;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  mul_stat_t                  mul_stat;
  logic signed [TERM_W-1:0]   mul_result;
  logic                       div_start;
  logic                       div_busy;
  logic [NUM_W-1:0]           div_quot;
  logic [NUM_W-1:0]           div_num;

  // Datapath helpers.
  logic signed [VAL_W:0]      err_raw;
  logic signed [VAL_W-1:0]    err_sat;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          diff_mag;
  logic signed [TERM_W:0]     int_sum;
  logic [SHI_W-1:0]           int_hi;
  logic signed [SUM_W-1:0]    int_sat;
  logic signed [RATE_W-1:0]   q_ext;
  logic signed [RATE_W-1:0]   rate_next;
  logic signed [TOTAL_W-1:0]  term_add;
  logic signed [VAL_W-1:0]    drive_next;

  assign sample_ready = (state == S_IDLE);

  // Error against the setpoint, saturated to the value width.
  always_comb begin
    err_raw = {target[VAL_W-1], target} - {measured[VAL_W-1], measured};
    if (err_raw[VAL_W] != err_raw[VAL_W-1]) begin
      err_sat = err_raw[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      err_sat = err_raw[VAL_W-1:0];
    end
  end

  // Change of error since the previous sample, as a magnitude for the divider.
  always_comb begin
    diff     = {err[VAL_W-1], err} - {prior_error[VAL_W-1], prior_error};
    diff_mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    div_num  = NUM_W'(diff_mag) << FRAC_BITS;
  end

  // Integral update, saturated to its Q32.16 width.
  always_comb begin
    int_sum = (TERM_W+1)'(error_sum) + (TERM_W+1)'(mul_result);
    int_hi  = int_sum[TERM_W:SUM_W-1];
    if ((int_hi == '0) || (int_hi == '1)) begin
      int_sat = int_sum[SUM_W-1:0];
    end else if (int_sum[TERM_W]) begin
      int_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      int_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  // Signed rate; a zero time step gives no derivative contribution.
  always_comb begin
    q_ext = {1'b0, div_quot};
    if (dt == '0) begin
      rate_next = '0;
    end else begin
      rate_next = dneg ? -q_ext : q_ext;
    end
  end

  // Running total of terms and the output clamp. The floor is tested first, so a floor
  // set above the ceiling still wins for sums below it.
  always_comb begin
    term_add = term_sum + TOTAL_W'(mul_result);
    if (term_sum < TOTAL_W'(drive_floor)) begin
      drive_next = drive_floor;
    end else if (term_sum > TOTAL_W'(drive_ceiling)) begin
      drive_next = drive_ceiling;
    end else begin
      drive_next = term_sum[VAL_W-1:0];
    end
  end

  // Operand selection for the shared multiplier. The gain of the integral term starts in
  // the same cycle as the proportional product is taken.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = gain_p;
    mul_b     = MUL_B_W'(err);
    div_start = 1'b0;
    case (state)
      S_PREP: begin
        mul_start = 1'b1;
        mul_a     = err;
        mul_b     = MUL_B_W'($signed({1'b0, dt}));
        div_start = 1'b1;
      end
      S_START_P: begin
        mul_start = 1'b1;
        mul_a     = gain_p;
        mul_b     = MUL_B_W'(err);
      end
      S_MUL_P: begin
        mul_start = mul_stat.done;
        mul_a     = gain_i;
        mul_b     = MUL_B_W'(error_sum);
      end
      S_START_D: begin
        mul_start = 1'b1;
        mul_a     = gain_d;
        mul_b     = MUL_B_W'(rate);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      drive_floor   <= {1'b1, {(VAL_W-1){1'b0}}};
      drive_ceiling <= {1'b0, {(VAL_W-1){1'b1}}};
      target        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_P:        gain_p        <= cfg_data;
        REG_GAIN_I:        gain_i        <= cfg_data;
        REG_GAIN_D:        gain_d        <= cfg_data;
        REG_DRIVE_FLOOR:   drive_floor   <= cfg_data;
        REG_DRIVE_CEILING: drive_ceiling <= cfg_data;
        REG_TARGET:        target        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer. The divider is started together with the first multiply and runs on
  // while the integral, proportional and integral-gain products are formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      error_sum   <= '0;
      prior_error <= '0;
      drive_valid <= 1'b0;
    end else begin
      // The clamp step refills the output register itself, so it is only emptied here
      // in the other states.
      if (drive_valid && drive_ready && (state != S_CLAMP)) begin
        drive_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            err   <= err_sat;
            dt    <= step_time;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          dneg  <= diff[DIFF_W-1];
          state <= S_MUL_INT;
        end
        S_MUL_INT: begin
          if (mul_stat.done) begin
            error_sum <= int_sat;
            state     <= S_START_P;
          end
        end
        S_START_P: begin
          state <= S_MUL_P;
        end
        S_MUL_P: begin
          if (mul_stat.done) begin
            term_sum <= TOTAL_W'(mul_result);
            state    <= S_MUL_I;
          end
        end
        S_MUL_I: begin
          if (mul_stat.done) begin
            term_sum <= term_add;
            state    <= S_WAIT_DIV;
          end
        end
        S_WAIT_DIV: begin
          if (!div_busy) begin
            rate  <= rate_next;
            state <= S_START_D;
          end
        end
        S_START_D: begin
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          if (mul_stat.done) begin
            term_sum <= term_add;
            state    <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          // Hold here while an earlier result still waits to be taken.
          if (!drive_valid || drive_ready) begin
            drive       <= drive_next;
            drive_valid <= 1'b1;
            prior_error <= err;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  pidcs_mul #(
    .CHUNK (MUL_CHUNK)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .stat   (mul_stat),
    .result (mul_result)
  );

  pidcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dt),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // The multiplier is never restarted while it is still working on a product.
  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  // A finished product only appears while the sequencer is waiting for one.
  a_mul_done_expected: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == S_MUL_INT || state == S_MUL_P ||
                       state == S_MUL_I || state == S_MUL_D))
    else $error("product delivered outside a multiply wait");

  // Both shared units are quiet whenever a new sample may be accepted.
  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mul_stat.busy && !div_busy))
    else $error("arithmetic unit still busy at idle");

  // The rate is only used after the divider has finished.
  a_rate_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_START_D) |-> !div_busy)
    else $error("derivative multiply started before the quotient was ready");

endmodule
